FILE: rtl/core/obb_pkg.sv
package obb_pkg;

  localparam int CMD_W       = 4;
  localparam int IN_BITS_DEF = 16;
  localparam int FRAC_BITS   = 14;
  localparam int NORM_BITS   = 15;
  localparam int OUT_W       = FRAC_BITS + 2;
  localparam int EPS_W       = 15;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(164);

  localparam logic [CMD_W-1:0] CMD_U  = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_V  = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_W_ = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_UV = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_VU = CMD_W'(4);
  localparam logic [CMD_W-1:0] CMD_UW = CMD_W'(5);
  localparam logic [CMD_W-1:0] CMD_WU = CMD_W'(6);
  localparam logic [CMD_W-1:0] CMD_VW = CMD_W'(7);
  localparam logic [CMD_W-1:0] CMD_WV = CMD_W'(8);

  typedef logic signed [OUT_W-1:0] comp_t;
  typedef logic signed [2*OUT_W-1:0] prod_t;

  localparam comp_t COMP_ONE  = comp_t'(1 << FRAC_BITS);
  localparam comp_t COMP_MONE = -COMP_ONE;
  localparam prod_t PROD_HALF = prod_t'(1 << (FRAC_BITS - 1));
  localparam prod_t PROD_ONE  = prod_t'(1 << FRAC_BITS);
  localparam prod_t PROD_MONE = -PROD_ONE;

  typedef struct packed {
    logic  degenerate;
    comp_t u_x;
    comp_t u_y;
    comp_t u_z;
    comp_t v_x;
    comp_t v_y;
    comp_t v_z;
    comp_t w_x;
    comp_t w_y;
    comp_t w_z;
  } result_t;

  // round a Q2.28 product sum to Q1.14 and clamp to +-1
  function automatic comp_t fx_round(input prod_t x);
    prod_t t;
    prod_t q;
    comp_t r;
    t = x + PROD_HALF;
    q = t >>> FRAC_BITS;
    if (q > PROD_ONE) begin
      r = COMP_ONE;
    end else if (q < PROD_MONE) begin
      r = COMP_MONE;
    end else begin
      r = q[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/obb_in_if.sv
interface obb_in_if
  import obb_pkg::*;
#(
  parameter int INPUT_BITS = IN_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic signed [INPUT_BITS-1:0] first_x;
  logic signed [INPUT_BITS-1:0] first_y;
  logic signed [INPUT_BITS-1:0] first_z;
  logic signed [INPUT_BITS-1:0] second_x;
  logic signed [INPUT_BITS-1:0] second_y;
  logic signed [INPUT_BITS-1:0] second_z;

  modport source (
    output valid, command, first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, command, first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

FILE: rtl/core/obb_out_if.sv
interface obb_out_if
  import obb_pkg::*;
;
  logic  valid;
  logic  ready;
  comp_t u_x;
  comp_t u_y;
  comp_t u_z;
  comp_t v_x;
  comp_t v_y;
  comp_t v_z;
  comp_t w_x;
  comp_t w_y;
  comp_t w_z;
  logic  degenerate;

  modport source (
    output valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, u_x, u_y, u_z, v_x, v_y, v_z, w_x, w_y, w_z, degenerate,
    output ready
  );
endinterface

FILE: rtl/core/obb_norm.sv
module obb_norm
  import obb_pkg::*;
#(
  parameter int VW  = 16,
  parameter int SBW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] in_vec [3],
  input  logic [SBW-1:0]       in_sb,
  output logic                 out_valid,
  output comp_t                out_vec [3],
  output logic                 out_zero,
  output logic [SBW-1:0]       out_sb
);

  localparam int MW     = (VW > NORM_BITS) ? VW : NORM_BITS;
  localparam int KS     = MW - NORM_BITS;
  localparam int LEN2_W = 2 * NORM_BITS + 2;
  localparam int LW     = (LEN2_W + 2 * FRAC_BITS) / 2;
  localparam int RW     = LW + 2;
  localparam int QW     = FRAC_BITS + 1;
  localparam int DW     = LW + QW;
  localparam int SW     = SBW + 4;
  localparam int NL     = KS + 5 + LW + QW;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  logic [SW-1:0]             side_r  [0:NL-1];
  logic                      vld_r   [0:NL-1];
  logic [VW-1:0]             mag_in  [3];
  logic [MW-1:0]             sh_m_r  [0:KS][0:2];
  logic [2*NORM_BITS-1:0]    sq_r    [3];
  logic [NORM_BITS-1:0]      mq_r    [0:LW+1][0:2];
  logic [LEN2_W-1:0]         len2_r  [0:LW-1];
  logic [LW-1:0]             root_r  [1:LW];
  logic [RW-1:0]             rem_r   [1:LW-1];
  logic [DW-1:0]             num_r   [0:QW-1][0:2];
  logic [LW-1:0]             dl_r    [0:QW-1];
  logic [QW-1:0]             q_r     [1:QW][0:2];
  comp_t                     out_r   [3];
  logic                      zero_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = in_vec[i][VW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
    end
    zero_in = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
  end

  // control and sideband line, one entry per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= {zero_in, in_vec[2][VW-1], in_vec[1][VW-1], in_vec[0][VW-1], in_sb};
      for (int i = 0; i < 3; i++) begin
        sh_m_r[0][i] <= MW'(mag_in[i]);
      end
    end
  end

  for (genvar s = 1; s < NL; s++) begin : g_line
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // one-bit range reduction per stage until all magnitudes fit
  for (genvar k = 0; k < KS; k++) begin : g_sh
    logic big;
    assign big = (sh_m_r[k][0][MW-1:NORM_BITS] != '0) ||
                 (sh_m_r[k][1][MW-1:NORM_BITS] != '0) ||
                 (sh_m_r[k][2][MW-1:NORM_BITS] != '0);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          sh_m_r[k+1][i] <= big ? (sh_m_r[k][i] >> 1) : sh_m_r[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mq_r[0][i] <= sh_m_r[KS][i][NORM_BITS-1:0];
        sq_r[i]    <= sh_m_r[KS][i][NORM_BITS-1:0] * sh_m_r[KS][i][NORM_BITS-1:0];
        mq_r[1][i] <= mq_r[0][i];
      end
      len2_r[0] <= LEN2_W'(sq_r[0]) + LEN2_W'(sq_r[1]) + LEN2_W'(sq_r[2]);
    end
  end

  // square root of len2 * 2^(2F), one root bit per stage
  for (genvar j = 0; j < LW; j++) begin : g_sqrt
    localparam int KB = LW - 1 - j;
    logic [LW-1:0] rt_p;
    logic [RW-1:0] rm_p;
    logic [1:0]    pair;
    logic [RW-1:0] rm_sh;
    logic [RW-1:0] trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign rt_p = '0;
      assign rm_p = '0;
    end else begin : g_next
      assign rt_p = root_r[j];
      assign rm_p = rem_r[j];
    end

    if (KB >= FRAC_BITS) begin : g_bits
      assign pair = len2_r[j][2*(KB-FRAC_BITS)+1 -: 2];
    end else begin : g_low
      assign pair = 2'b00;
    end

    assign rm_sh = {rm_p[RW-3:0], pair};
    assign trial = {rt_p, 2'b01};
    assign ge    = (rm_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j+1] <= {rt_p[LW-2:0], ge};
        mq_r[j+2]   <= mq_r[j+1];
      end
    end

    if (j < LW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1]  <= ge ? (rm_sh - trial) : rm_sh;
          len2_r[j+1] <= len2_r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[0][i] <= (DW'(mq_r[LW+1][i]) << (2 * FRAC_BITS)) + DW'(root_r[LW] >> 1);
      end
      dl_r[0] <= root_r[LW];
    end
  end

  // restoring divide by the length, one quotient bit per stage
  for (genvar jj = 0; jj < QW; jj++) begin : g_div
    localparam int B = QW - 1 - jj;
    logic [DW-1:0] d;
    logic [QW-1:0] qp [3];
    logic          ge [3];

    assign d = DW'(dl_r[jj]) << B;
    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (jj == 0) begin : g_first
        assign qp[i] = '0;
      end else begin : g_next
        assign qp[i] = q_r[jj][i];
      end
      assign ge[i] = (num_r[jj][i] >= d);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          q_r[jj+1][i] <= {qp[i][QW-2:0], ge[i]};
        end
      end
    end

    if (jj < QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          for (int i = 0; i < 3; i++) begin
            num_r[jj+1][i] <= ge[i] ? (num_r[jj][i] - d) : num_r[jj][i];
          end
          dl_r[jj+1] <= dl_r[jj];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_r[i] <= side_r[NL-2][SBW+i] ? -comp_t'({1'b0, (q_r[QW][i] > ONE_Q) ? ONE_Q : q_r[QW][i]})
                                        :  comp_t'({1'b0, (q_r[QW][i] > ONE_Q) ? ONE_Q : q_r[QW][i]});
      end
    end
  end

  assign out_valid = vld_r[NL-1];
  assign out_vec   = out_r;
  assign out_zero  = side_r[NL-1][SW-1];
  assign out_sb    = side_r[NL-1][SBW-1:0];

endmodule

FILE: rtl/core/obb_skid.sv
module obb_skid #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  input  logic [W-1:0] push_data,
  output logic         en,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  localparam logic [1:0] CNT_FULL = 2'd2;

  logic [W-1:0] d0_r, d0_nxt;
  logic [W-1:0] d1_r, d1_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         push;
  logic         pop;
  logic [1:0]   pos;

  assign en        = (cnt_r != CNT_FULL);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = d0_r;
  assign push      = push_valid && en;
  assign pop       = out_valid && out_ready;
  assign pos       = cnt_r - {1'b0, pop};

  always_comb begin
    d0_nxt  = pop ? d1_r : d0_r;
    d1_nxt  = d1_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    if (push) begin
      if (pos == 2'd0) begin
        d0_nxt = push_data;
      end else begin
        d1_nxt = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
  end

endmodule

FILE: rtl/core/orthonormal_basis_builder.sv
// Builds a right-handed orthonormal basis (U, V, W in Q1.14) from a command and one or two
// signed vectors. One word is accepted every clock while the output side takes words; a
// two-word output buffer lets the input keep flowing while a result waits. The datapath is
// two normalizers in series, each a range reduction (one bit per stage), a square root
// (one root bit per stage, 30 stages) and three parallel restoring dividers (15 stages).
// epsilon is registered on its write, and its square is registered from that register.
module orthonormal_basis_builder
  import obb_pkg::*;
#(
  parameter int INPUT_BITS = IN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [EPS_W-1:0] cfg_wdata,
  obb_in_if.sink           in_s,
  obb_out_if.source        out_s
);

  localparam int IB  = INPUT_BITS;
  localparam int CW  = 2 * IB + 1;
  localparam int SB1 = CMD_W + 3 * CW;
  localparam int SB2 = CMD_W + 1 + 3 * OUT_W;
  localparam int SQW = 2 * FRAC_BITS + 2;

  logic                   en;
  logic [EPS_W-1:0]       eps_r;
  logic [2*EPS_W-1:0]     eps_sq_r;

  // input and raw cross stages
  logic                   v0_r, v1_r, v2_r;
  logic [CMD_W-1:0]       cmd0_r, cmd1_r, cmd2_r;
  logic signed [IB-1:0]   p0_r [3];
  logic signed [IB-1:0]   q0_r [3];
  logic signed [IB-1:0]   p1_r [3];
  logic signed [IB-1:0]   p2_r [3];
  logic signed [IB-1:0]   ca [3];
  logic signed [IB-1:0]   cb [3];
  logic signed [2*IB-1:0] pr_r [6];
  logic signed [CW-1:0]   c2_r [3];
  logic                   swap_raw;

  // first normalizer
  logic                   n1_v;
  comp_t                  n1_a [3];
  logic                   n1_z;
  logic [SB1-1:0]         n1_sb;
  logic [CMD_W-1:0]       n1_cmd;
  logic signed [CW-1:0]   n1_c [3];

  // perpendicular select stages
  logic                   pv1_r, pv2_r;
  logic [CMD_W-1:0]       pcmd1_r, pcmd2_r;
  logic                   pz1_r, pz2_r;
  comp_t                  pa1_r [3];
  comp_t                  pa2_r [3];
  logic signed [CW-1:0]   pc1_r [3];
  logic [2*FRAC_BITS:0]   sqa_r [2];
  logic signed [CW-1:0]   b_in_r [3];
  prod_t                  sq_a1, sq_a2;
  logic [SQW-1:0]         plen2;
  logic                   short_x;
  logic                   single;
  comp_t                  neg_a1, neg_a2;

  // second normalizer
  logic                   n2_v;
  comp_t                  n2_b [3];
  logic                   n2_z;
  logic [SB2-1:0]         n2_sb;
  logic [CMD_W-1:0]       n2_cmd;
  logic                   n2_z1;
  comp_t                  n2_a [3];

  // final cross stages
  logic                   fv_r;
  logic [CMD_W-1:0]       fcmd_r;
  logic                   fz_r;
  comp_t                  fa_r [3];
  comp_t                  fb_r [3];
  prod_t                  fp_r [6];
  comp_t                  fx [3];
  comp_t                  fy [3];
  logic                   swap_fx;
  comp_t                  t [3];
  result_t                res;
  result_t                out_word;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r    <= EPS_RESET;
      eps_sq_r <= (2*EPS_W)'(EPS_RESET) * (2*EPS_W)'(EPS_RESET);
    end else begin
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
      eps_sq_r <= eps_r * eps_r;
    end
  end

  assign in_s.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_s.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // pair modes that cross second by first
  assign swap_raw = (cmd0_r == CMD_VU) || (cmd0_r == CMD_UW) || (cmd0_r == CMD_WV);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ca[i] = swap_raw ? q0_r[i] : p0_r[i];
      cb[i] = swap_raw ? p0_r[i] : q0_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r  <= in_s.command;
      p0_r[0] <= in_s.first_x;
      p0_r[1] <= in_s.first_y;
      p0_r[2] <= in_s.first_z;
      q0_r[0] <= in_s.second_x;
      q0_r[1] <= in_s.second_y;
      q0_r[2] <= in_s.second_z;

      cmd1_r  <= cmd0_r;
      p1_r    <= p0_r;
      pr_r[0] <= ca[1] * cb[2];
      pr_r[1] <= ca[2] * cb[1];
      pr_r[2] <= ca[2] * cb[0];
      pr_r[3] <= ca[0] * cb[2];
      pr_r[4] <= ca[0] * cb[1];
      pr_r[5] <= ca[1] * cb[0];

      cmd2_r  <= cmd1_r;
      p2_r    <= p1_r;
      for (int i = 0; i < 3; i++) begin
        c2_r[i] <= {pr_r[2*i][2*IB-1], pr_r[2*i]} - {pr_r[2*i+1][2*IB-1], pr_r[2*i+1]};
      end
    end
  end

  obb_norm #(
    .VW  (IB),
    .SBW (SB1)
  ) u_norm_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_vec    (p2_r),
    .in_sb     ({cmd2_r, c2_r[0], c2_r[1], c2_r[2]}),
    .out_valid (n1_v),
    .out_vec   (n1_a),
    .out_zero  (n1_z),
    .out_sb    (n1_sb)
  );

  assign n1_cmd  = n1_sb[SB1-1 -: CMD_W];
  assign n1_c[0] = n1_sb[3*CW-1 -: CW];
  assign n1_c[1] = n1_sb[2*CW-1 -: CW];
  assign n1_c[2] = n1_sb[CW-1 -: CW];

  // x-axis cross length test and choice of the second vector
  assign sq_a2   = n1_a[2] * n1_a[2];
  assign sq_a1   = n1_a[1] * n1_a[1];
  assign plen2   = SQW'(sqa_r[0]) + SQW'(sqa_r[1]);
  assign short_x = ({{(2*EPS_W){1'b0}}, plen2} < {{SQW{1'b0}}, eps_sq_r});
  assign single  = (pcmd1_r == CMD_U) || (pcmd1_r == CMD_V) || (pcmd1_r == CMD_W_);
  assign neg_a1  = -pa1_r[1];
  assign neg_a2  = -pa1_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv1_r <= 1'b0;
      pv2_r <= 1'b0;
    end else if (en) begin
      pv1_r <= n1_v;
      pv2_r <= pv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcmd1_r  <= n1_cmd;
      pz1_r    <= n1_z;
      pa1_r    <= n1_a;
      pc1_r    <= n1_c;
      sqa_r[0] <= sq_a2[2*FRAC_BITS:0];
      sqa_r[1] <= sq_a1[2*FRAC_BITS:0];

      pcmd2_r  <= pcmd1_r;
      pz2_r    <= pz1_r;
      pa2_r    <= pa1_r;
      if (!single) begin
        b_in_r <= pc1_r;
      end else if (short_x) begin
        b_in_r[0] <= CW'(neg_a2);
        b_in_r[1] <= '0;
        b_in_r[2] <= CW'(pa1_r[0]);
      end else begin
        b_in_r[0] <= '0;
        b_in_r[1] <= CW'(pa1_r[2]);
        b_in_r[2] <= CW'(neg_a1);
      end
    end
  end

  obb_norm #(
    .VW  (CW),
    .SBW (SB2)
  ) u_norm_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pv2_r),
    .in_vec    (b_in_r),
    .in_sb     ({pcmd2_r, pz2_r, pa2_r[0], pa2_r[1], pa2_r[2]}),
    .out_valid (n2_v),
    .out_vec   (n2_b),
    .out_zero  (n2_z),
    .out_sb    (n2_sb)
  );

  assign n2_cmd  = n2_sb[SB2-1 -: CMD_W];
  assign n2_z1   = n2_sb[3*OUT_W];
  assign n2_a[0] = n2_sb[3*OUT_W-1 -: OUT_W];
  assign n2_a[1] = n2_sb[2*OUT_W-1 -: OUT_W];
  assign n2_a[2] = n2_sb[OUT_W-1 -: OUT_W];

  // third axis: second by first for these modes
  assign swap_fx = (n2_cmd == CMD_V) || (n2_cmd == CMD_UV) ||
                   (n2_cmd == CMD_WU) || (n2_cmd == CMD_VW);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fx[i] = swap_fx ? n2_b[i] : n2_a[i];
      fy[i] = swap_fx ? n2_a[i] : n2_b[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= n2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fcmd_r  <= n2_cmd;
      fz_r    <= n2_z1 || n2_z;
      fa_r    <= n2_a;
      fb_r    <= n2_b;
      fp_r[0] <= fx[1] * fy[2];
      fp_r[1] <= fx[2] * fy[1];
      fp_r[2] <= fx[2] * fy[0];
      fp_r[3] <= fx[0] * fy[2];
      fp_r[4] <= fx[0] * fy[1];
      fp_r[5] <= fx[1] * fy[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i] = fx_round(fp_r[2*i] - fp_r[2*i+1]);
    end
    res = '0;
    unique case (fcmd_r)
      CMD_U, CMD_UW: begin
        {res.u_x, res.u_y, res.u_z} = {fa_r[0], fa_r[1], fa_r[2]};
        {res.v_x, res.v_y, res.v_z} = {fb_r[0], fb_r[1], fb_r[2]};
        {res.w_x, res.w_y, res.w_z} = {t[0], t[1], t[2]};
      end
      CMD_V, CMD_VW: begin
        {res.v_x, res.v_y, res.v_z} = {fa_r[0], fa_r[1], fa_r[2]};
        {res.u_x, res.u_y, res.u_z} = {fb_r[0], fb_r[1], fb_r[2]};
        {res.w_x, res.w_y, res.w_z} = {t[0], t[1], t[2]};
      end
      CMD_W_, CMD_WV: begin
        {res.w_x, res.w_y, res.w_z} = {fa_r[0], fa_r[1], fa_r[2]};
        {res.u_x, res.u_y, res.u_z} = {fb_r[0], fb_r[1], fb_r[2]};
        {res.v_x, res.v_y, res.v_z} = {t[0], t[1], t[2]};
      end
      CMD_UV: begin
        {res.u_x, res.u_y, res.u_z} = {fa_r[0], fa_r[1], fa_r[2]};
        {res.w_x, res.w_y, res.w_z} = {fb_r[0], fb_r[1], fb_r[2]};
        {res.v_x, res.v_y, res.v_z} = {t[0], t[1], t[2]};
      end
      CMD_VU: begin
        {res.v_x, res.v_y, res.v_z} = {fa_r[0], fa_r[1], fa_r[2]};
        {res.w_x, res.w_y, res.w_z} = {fb_r[0], fb_r[1], fb_r[2]};
        {res.u_x, res.u_y, res.u_z} = {t[0], t[1], t[2]};
      end
      CMD_WU: begin
        {res.w_x, res.w_y, res.w_z} = {fa_r[0], fa_r[1], fa_r[2]};
        {res.v_x, res.v_y, res.v_z} = {fb_r[0], fb_r[1], fb_r[2]};
        {res.u_x, res.u_y, res.u_z} = {t[0], t[1], t[2]};
      end
      default: begin
        res = '0;
      end
    endcase
    // zero-length vector: all components zero, flag set
    if (fcmd_r <= CMD_WV && fz_r) begin
      res            = '0;
      res.degenerate = 1'b1;
    end
  end

  obb_skid #(
    .W ($bits(result_t))
  ) u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fv_r),
    .push_data  (res),
    .en         (en),
    .out_valid  (out_s.valid),
    .out_ready  (out_s.ready),
    .out_data   (out_word)
  );

  assign out_s.u_x        = out_word.u_x;
  assign out_s.u_y        = out_word.u_y;
  assign out_s.u_z        = out_word.u_z;
  assign out_s.v_x        = out_word.v_x;
  assign out_s.v_y        = out_word.v_y;
  assign out_s.v_z        = out_word.v_z;
  assign out_s.w_x        = out_word.w_x;
  assign out_s.w_y        = out_word.w_y;
  assign out_s.w_z        = out_word.w_z;
  assign out_s.degenerate = out_word.degenerate;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import obb_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 160;
  localparam int LONG_HOLD      = 400;
  localparam int ITEMS_PER_PHASE = 100;
  // more than the pipeline holds, so the long hold-off stalls the input
  localparam int PRESSURE_ITEMS  = 200;

  typedef longint vec3_t [3];

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic signed [15:0] fx, fy, fz;
    logic signed [15:0] sx, sy, sz;
  } item_t;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [EPS_W-1:0] cfg_wdata;

  obb_in_if #(.INPUT_BITS(16)) in_ch ();
  obb_out_if out_ch ();

  orthonormal_basis_builder #(.INPUT_BITS(16)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_s      (in_ch),
    .out_s     (out_ch)
  );

  result_t basis_q[$];
  row_t    directed_rows[$];
  longint unsigned eps_now;
  int      error_count;
  int      src_idle_pct;
  int      snk_stall_pct;
  bit      long_hold_req;
  int      hold_left;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit make_unit(input vec3_t a, output vec3_t r);
    longint unsigned m [3];
    longint unsigned mx;
    longint unsigned len2;
    longint unsigned root;
    longint unsigned q;
    int s;
    r = '{0, 0, 0};
    mx = 0;
    len2 = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (a[i] < 0) ? longint'(-a[i]) : a[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (s < 63 && (mx >> s) >= (64'd1 << NORM_BITS)) s++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> s;
      len2 += m[i] * m[i];
    end
    root = int_sqrt(len2 << (2 * FRAC_BITS));
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (2 * FRAC_BITS)) + (root >> 1)) / root;
      if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
      r[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic void cross_wide(input vec3_t a, input vec3_t b, output vec3_t r);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint round_q14(input longint x);
    longint q;
    q = (x + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (q > (64'sd1 << FRAC_BITS)) q = 64'sd1 << FRAC_BITS;
    if (q < -(64'sd1 << FRAC_BITS)) q = -(64'sd1 << FRAC_BITS);
    return q;
  endfunction

  function automatic void cross_unit(input vec3_t a, input vec3_t b, output vec3_t r);
    vec3_t w;
    cross_wide(a, b, w);
    for (int i = 0; i < 3; i++) r[i] = round_q14(w[i]);
  endfunction

  // a x X, or a x Y when that comes out shorter than epsilon
  function automatic bit perp_axis(input vec3_t a, output vec3_t r);
    vec3_t c;
    longint unsigned len2;
    c = '{0, a[2], -a[1]};
    len2 = longint'(a[2] * a[2]) + longint'(a[1] * a[1]);
    if (len2 < eps_now * eps_now) c = '{-a[2], 0, a[0]};
    return make_unit(c, r);
  endfunction

  function automatic result_t predict_basis(input item_t it);
    vec3_t p, q, c, bu, bv, bw;
    bit ok;
    bit known;
    result_t res;
    p = '{longint'(it.fx), longint'(it.fy), longint'(it.fz)};
    q = '{longint'(it.sx), longint'(it.sy), longint'(it.sz)};
    bu = '{0, 0, 0};
    bv = '{0, 0, 0};
    bw = '{0, 0, 0};
    ok = 1'b1;
    known = 1'b1;
    case (it.cmd)
      CMD_U: begin
        ok = make_unit(p, bu) && perp_axis(bu, bv);
        if (ok) cross_unit(bu, bv, bw);
      end
      CMD_V: begin
        ok = make_unit(p, bv) && perp_axis(bv, bu);
        if (ok) cross_unit(bu, bv, bw);
      end
      CMD_W_: begin
        ok = make_unit(p, bw) && perp_axis(bw, bu);
        if (ok) cross_unit(bw, bu, bv);
      end
      CMD_UV: begin
        cross_wide(p, q, c);
        ok = make_unit(p, bu) && make_unit(c, bw);
        if (ok) cross_unit(bw, bu, bv);
      end
      CMD_VU: begin
        cross_wide(q, p, c);
        ok = make_unit(p, bv) && make_unit(c, bw);
        if (ok) cross_unit(bv, bw, bu);
      end
      CMD_UW: begin
        cross_wide(q, p, c);
        ok = make_unit(p, bu) && make_unit(c, bv);
        if (ok) cross_unit(bu, bv, bw);
      end
      CMD_WU: begin
        cross_wide(p, q, c);
        ok = make_unit(p, bw) && make_unit(c, bv);
        if (ok) cross_unit(bv, bw, bu);
      end
      CMD_VW: begin
        cross_wide(p, q, c);
        ok = make_unit(p, bv) && make_unit(c, bu);
        if (ok) cross_unit(bu, bv, bw);
      end
      CMD_WV: begin
        cross_wide(q, p, c);
        ok = make_unit(p, bw) && make_unit(c, bu);
        if (ok) cross_unit(bw, bu, bv);
      end
      default: known = 1'b0;
    endcase
    res = '0;
    if (ok && known) begin
      res.u_x = comp_t'(bu[0]); res.u_y = comp_t'(bu[1]); res.u_z = comp_t'(bu[2]);
      res.v_x = comp_t'(bv[0]); res.v_y = comp_t'(bv[1]); res.v_z = comp_t'(bv[2]);
      res.w_x = comp_t'(bw[0]); res.w_y = comp_t'(bw[1]); res.w_z = comp_t'(bw[2]);
    end
    res.degenerate = known && !ok;
    return res;
  endfunction

  // ---------------- checking ----------------

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic check_comp(input string what, input comp_t got, input comp_t want);
    if (got !== want) report(what, longint'(got), longint'(want));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (basis_q.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        want = basis_q.pop_front();
        if (out_ch.degenerate !== want.degenerate)
          report("degenerate", out_ch.degenerate, want.degenerate);
        check_comp("u_x", out_ch.u_x, want.u_x);
        check_comp("u_y", out_ch.u_y, want.u_y);
        check_comp("u_z", out_ch.u_z, want.u_z);
        check_comp("v_x", out_ch.v_x, want.v_x);
        check_comp("v_y", out_ch.v_y, want.v_y);
        check_comp("v_z", out_ch.v_z, want.v_z);
        check_comp("w_x", out_ch.w_x, want.w_x);
        check_comp("w_y", out_ch.w_y, want.w_y);
        check_comp("w_z", out_ch.w_z, want.w_z);
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req && hold_left == 0) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_word(input item_t it, input bit typed, input result_t want);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= it.cmd;
    in_ch.first_x  <= it.fx;
    in_ch.first_y  <= it.fy;
    in_ch.first_z  <= it.fz;
    in_ch.second_x <= it.sx;
    in_ch.second_y <= it.sy;
    in_ch.second_z <= it.sz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    basis_q.push_back(typed ? want : predict_basis(it));
  endtask

  task automatic wait_drained();
    while (basis_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    eps_now = value;
    // wait for the new value and its square to settle
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp(input int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(16)) - 8);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($signed($urandom_range(400)) - 200);
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int st;
    int k;
    st = $urandom_range(3);
    it.cmd = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(15, 9))
                                       : CMD_W'($urandom_range(8));
    it.fx = rand_comp(st);
    it.fy = rand_comp(st);
    it.fz = rand_comp(st);
    it.sx = rand_comp($urandom_range(3));
    it.sy = rand_comp($urandom_range(3));
    it.sz = rand_comp($urandom_range(3));
    case ($urandom_range(9))
      // nearly along x, so the y-axis fallback kicks in
      0: begin
        it.fx = rand_comp(0);
        it.fy = rand_comp(1);
        it.fz = rand_comp(1);
      end
      // parallel pair
      1: begin
        k = $urandom_range(3) - 2;
        it.fx = rand_comp(1); it.fy = rand_comp(1); it.fz = rand_comp(1);
        it.sx = 16'(it.fx * k); it.sy = 16'(it.fy * k); it.sz = 16'(it.fz * k);
      end
      2: if ($urandom_range(3) == 0) begin
        it.fx = 0; it.fy = 0; it.fz = 0;
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd,
                         input int fx, input int fy, input int fz,
                         input int sx, input int sy, input int sz,
                         input bit typed, input result_t want);
    row_t r;
    r.it = '{cmd, 16'(fx), 16'(fy), 16'(fz), 16'(sx), 16'(sy), 16'(sz)};
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  initial begin
    result_t none;
    result_t degen;
    result_t x_basis;
    int eps_list [4];
    none = '0;
    degen = '0;
    degen.degenerate = 1'b1;
    x_basis = '0;
    x_basis.u_x = COMP_ONE;
    x_basis.v_z = COMP_ONE;
    x_basis.w_y = COMP_MONE;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.first_x = '0;
    in_ch.first_y = '0;
    in_ch.first_z = '0;
    in_ch.second_x = '0;
    in_ch.second_y = '0;
    in_ch.second_z = '0;
    eps_now = EPS_RESET;
    error_count = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    long_hold_req = 1'b0;
    quiet_cycles = 0;

    add_row(CMD_U,  16384, 0, 0, 0, 0, 0, 1'b1, x_basis);
    add_row(CMD_U,  0, 0, 0, 0, 0, 0, 1'b1, degen);
    add_row(CMD_V,  0, 0, 0, 5, 5, 5, 1'b1, degen);
    add_row(CMD_W_, 0, 0, 0, 1, 0, 0, 1'b1, degen);
    add_row(4'd9,   100, 200, 300, 4, 5, 6, 1'b1, none);
    add_row(4'd15,  -32768, 32767, -1, 1, 1, 1, 1'b1, none);
    add_row(CMD_UV, 1, 2, 3, 2, 4, 6, 1'b1, degen);
    add_row(CMD_WV, 3, -1, 2, 0, 0, 0, 1'b1, degen);
    add_row(CMD_U,  32767, 32767, 32767, 0, 0, 0, 1'b0, none);
    add_row(CMD_V,  -32768, -32768, -32768, 0, 0, 0, 1'b0, none);
    add_row(CMD_W_, 0, 0, -32768, 0, 0, 0, 1'b0, none);
    add_row(CMD_U,  30000, 1, -1, 0, 0, 0, 1'b0, none);
    add_row(CMD_UV, 32767, 0, 0, 0, -32768, 0, 1'b0, none);
    add_row(CMD_VU, -32768, 32767, 0, 32767, 32767, -32768, 1'b0, none);
    add_row(CMD_UW, 1, 0, 0, 0, 0, 1, 1'b0, none);
    add_row(CMD_WU, 3, 4, 5, -7, 2, 9, 1'b0, none);
    add_row(CMD_VW, -32768, -32768, -32768, 32767, -32768, 32767, 1'b0, none);
    add_row(CMD_WV, 12, -300, 7, 5000, 1, -20000, 1'b0, none);
    add_row(CMD_UV, 1, 1, 0, -1, 1, 0, 1'b0, none);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

    eps_list = '{1, 16384, 0, 8000};
    eps_list[2] = $urandom_range(16384, 1);
    for (int ph = 0; ph < 4; ph++) begin
      in_ch.valid <= 1'b0;
      write_epsilon(EPS_W'(eps_list[ph]));
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  long_hold_req = 1'b1; end
        1: begin src_idle_pct = 75; snk_stall_pct = 0;  long_hold_req = 1'b0; end
        2: begin src_idle_pct = 0;  snk_stall_pct = 75; end
        default: begin src_idle_pct = 30; snk_stall_pct = 30; end
      endcase
      for (int n = 0; n < ((ph == 0) ? PRESSURE_ITEMS : ITEMS_PER_PHASE); n++) begin
        if (n == 5) long_hold_req = 1'b0;
        send_word(rand_item(), 1'b0, none);
      end
    end
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
